/* rtl/core/voxel_row_store_fletcher32_unit_defines.svh */
// Assertion macros shared by the checker files of the voxel row store.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef VOXEL_ROW_STORE_FLETCHER32_UNIT_DEFINES_SVH
`define VOXEL_ROW_STORE_FLETCHER32_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define VRSF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define VRSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/vrsf_pkg.sv */
// Package for the voxel row store with Fletcher-32 checksum.
// Holds sizes, operation codes, the controller state type and the command
// and status structs; no dependencies.
`default_nettype none

package vrsf_pkg;

  localparam int VRSF_LAYERS     = 24;
  localparam int VRSF_ROWS       = 16;
  localparam int VRSF_FOLD_BLOCK = 360;
  localparam int VRSF_BLK_W      = $clog2(VRSF_FOLD_BLOCK);
  localparam logic [31:0] VRSF_SUM_INIT = 32'h0000_ffff;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FOLD,
    ST_FINAL,
    ST_READ,
    ST_DONE
  } vrsf_state_t;

  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic item_wr;
    logic cnt_clr;
    logic cnt_step;
    logic sweep_rd;
    logic item_rd;
    logic acc;
    logic fold;
    logic init;
    logic store_sum;
    logic load_out;
  } vrsf_cmd_t;

  typedef struct packed {
    logic op_read;
    logic cnt_last;
    logic blk_last;
  } vrsf_sts_t;

endpackage

`default_nettype wire

/* rtl/core/voxel_row_store_fletcher32_unit.sv */
// Top level of the voxel row store with Fletcher-32 checksum.
// Joins the controller and the datapath; depends on vrsf_pkg, vrsf_ctrl and
// vrsf_dpath.
//
// Usage:
// The input channel takes one item per handshake: a write stores in_row_bits
// at row word layer*16+row, a read returns bit in_bit_index of the word at
// layer*16+(15-row). Each item gives exactly one result item on the output
// channel, carrying the voxel bit (zero on writes) and the current checksum.
// After a write the whole store is swept through the single RAM read port,
// one word per cycle, with a drain and a fold step after each block of up to 360
// words and a final fold that stores the checksum before the result is
// loaded; a read reads its word from the RAM and then loads the result. One
// item is worked on at a time; in_stall drops again in the cycle after the
// result is loaded, so a new item is only taken after the last result is loaded.
// After reset all LAYERS*16 words of the store are cleared one word per cycle
// while in_stall stays high; the checksum reads zero until the first write.
// While out_stall is high the result holds, and a finished item waits in the
// controller until the output register is free.
`default_nettype none

module voxel_row_store_fletcher32_unit
  import vrsf_pkg::*;
#(
  parameter int LAYERS = VRSF_LAYERS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [4:0]  in_layer,
  input  wire logic [3:0]  in_row,
  input  wire logic [3:0]  in_bit_index,
  input  wire logic [15:0] in_row_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_voxel_filled,
  output logic [31:0]      out_checksum
);

  vrsf_cmd_t cmd;
  vrsf_sts_t sts;

  vrsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vrsf_dpath #(
    .LAYERS(LAYERS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_layer        (in_layer),
    .in_row          (in_row),
    .in_bit_index    (in_bit_index),
    .in_row_bits     (in_row_bits),
    .out_voxel_filled(out_voxel_filled),
    .out_checksum    (out_checksum)
  );

endmodule

`default_nettype wire

/* rtl/core/vrsf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vrsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/vrsf_ctrl.sv */
// Controller state machine of the voxel row store: clearing pass, item
// sequencing, checksum sweep and output handshake. Depends on vrsf_pkg.
`default_nettype none

module vrsf_ctrl
  import vrsf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire vrsf_sts_t sts,
  output vrsf_cmd_t      cmd
);

  vrsf_state_t state_r, state_nxt;
  logic        prev_issue_r, prev_issue_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      prev_issue_r <= 1'b0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      prev_issue_r <= prev_issue_nxt;
      last_r       <= last_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    last_nxt       = last_r;
    prev_issue_nxt = (state_r == ST_ISSUE);
    out_valid_nxt  = out_valid_r && out_stall;
    cmd            = '0;
    in_stall       = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr   = 1'b1;
        cmd.cnt_step = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (sts.op_read) begin
          cmd.item_rd = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          cmd.item_wr = 1'b1;
          cmd.cnt_clr = 1'b1;
          cmd.init    = 1'b1;
          last_nxt    = 1'b0;
          state_nxt   = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.sweep_rd = 1'b1;
        cmd.cnt_step = 1'b1;
        cmd.acc      = prev_issue_r;
        if (sts.cnt_last) begin
          last_nxt = 1'b1;
        end
        if (sts.cnt_last || sts.blk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.acc   = 1'b1;
        state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = last_r ? ST_FINAL : ST_ISSUE;
      end
      ST_FINAL: begin
        cmd.store_sum = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_READ: begin
        cmd.item_rd = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/vrsf_dpath.sv */
// Datapath of the voxel row store: item registers, sweep counters, the
// Fletcher-32 sums, the row store RAM and the result registers.
// Depends on vrsf_pkg and vrsf_ram.
`default_nettype none

module vrsf_dpath
  import vrsf_pkg::*;
#(
  parameter int LAYERS = VRSF_LAYERS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire vrsf_cmd_t   cmd,
  output vrsf_sts_t        sts,
  input  wire logic        in_operation,
  input  wire logic [4:0]  in_layer,
  input  wire logic [3:0]  in_row,
  input  wire logic [3:0]  in_bit_index,
  input  wire logic [15:0] in_row_bits,
  output logic             out_voxel_filled,
  output logic [31:0]      out_checksum
);

  localparam int WORDS = LAYERS * VRSF_ROWS;
  localparam int AW    = $clog2(WORDS);

  function automatic logic [31:0] fold16(input logic [31:0] s);
    fold16 = {16'h0000, s[15:0]} + {16'h0000, s[31:16]};
  endfunction

  logic              op_r;
  logic [4:0]        layer_r;
  logic [3:0]        row_r;
  logic [3:0]        bit_r;
  logic [15:0]       bits_r;
  logic [AW-1:0]     cnt_r;
  logic [VRSF_BLK_W-1:0] blk_r;
  logic [31:0]       s1_r;
  logic [31:0]       s2_r;
  logic [31:0]       sum_r;
  logic              filled_r;
  logic [31:0]       chk_out_r;

  logic              in_range;
  logic [AW-1:0]     item_addr;
  logic [AW-1:0]     mirror_addr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [15:0]       ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [15:0]       ram_rdata;
  logic [31:0]       word_ext;
  logic [31:0]       s1_fold;
  logic [31:0]       s2_fold;

  assign in_range    = {2'b00, layer_r} < 7'(LAYERS);
  assign item_addr   = AW'({layer_r, row_r});
  assign mirror_addr = AW'({layer_r, ~row_r});

  assign ram_we    = cmd.clr_wr || (cmd.item_wr && in_range);
  assign ram_waddr = cmd.clr_wr ? cnt_r : item_addr;
  assign ram_wdata = cmd.clr_wr ? 16'h0000 : bits_r;
  assign ram_re    = cmd.sweep_rd || cmd.item_rd;
  assign ram_raddr = cmd.sweep_rd ? cnt_r : mirror_addr;
  assign word_ext  = {16'h0000, ram_rdata};
  assign s1_fold   = fold16(s1_r);
  assign s2_fold   = fold16(s2_r);

  vrsf_ram #(
    .WIDTH(16),
    .DEPTH(WORDS)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re     (ram_re),
    .raddr  (ram_raddr),
    .rdata_r(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_operation;
      layer_r <= in_layer;
      row_r   <= in_row;
      bit_r   <= in_bit_index;
      bits_r  <= in_row_bits;
    end
    if (cmd.init) begin
      s1_r <= VRSF_SUM_INIT;
      s2_r <= VRSF_SUM_INIT;
    end else if (cmd.acc) begin
      s1_r <= s1_r + word_ext;
      s2_r <= s2_r + s1_r + word_ext;
    end else if (cmd.fold || cmd.store_sum) begin
      s1_r <= s1_fold;
      s2_r <= s2_fold;
    end
    if (cmd.load_out) begin
      filled_r  <= (op_r == OP_READ) && in_range && ram_rdata[bit_r];
      chk_out_r <= sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      blk_r <= '0;
      sum_r <= '0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
        blk_r <= '0;
      end else begin
        if (cmd.cnt_step) begin
          cnt_r <= cnt_r + AW'(1);
          blk_r <= blk_r + VRSF_BLK_W'(1);
        end
        if (cmd.fold) begin
          blk_r <= '0;
        end
      end
      if (cmd.store_sum) begin
        sum_r <= {s2_fold[15:0], s1_fold[15:0]};
      end
    end
  end

  assign sts.op_read  = (op_r == OP_READ);
  assign sts.cnt_last = (cnt_r == AW'(WORDS - 1));
  assign sts.blk_last = (blk_r == VRSF_BLK_W'(VRSF_FOLD_BLOCK - 1));

  assign out_voxel_filled = filled_r;
  assign out_checksum     = chk_out_r;

endmodule

`default_nettype wire

/* rtl/core/vrsf_checker.sv */
// Port-level checker for the voxel row store, bound to the top level.
// Depends on voxel_row_store_fletcher32_unit_defines.svh.
`default_nettype none

`include "voxel_row_store_fletcher32_unit_defines.svh"

module vrsf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_voxel_filled,
  input wire logic [31:0] out_checksum
);

  `VRSF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `VRSF_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_checksum) && $stable(out_voxel_filled), "stalled result changed")
  `VRSF_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item accepted while one is in work")
  `VRSF_ASSERT_NEXT(a_min_latency, in_valid && !in_stall, !$rose(out_valid), "result too early after an item")

endmodule

bind voxel_row_store_fletcher32_unit vrsf_checker u_vrsf_checker (.*);

`default_nettype wire
